@@ rtl/core/tcp_client_segment_fsm_top_assert.svh @@
// Assertion macros for the TCP client segment receiver.
// Taken by the modules that check their own logic; set ASSERT_OFF to drop them.
`ifndef TCP_CLIENT_SEGMENT_FSM_TOP_ASSERT_SVH
`define TCP_CLIENT_SEGMENT_FSM_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define TCPCS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tcpcs assertion failed");
// Antecedent implies consequent in the next cycle.
`define TCPCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tcpcs assertion failed");
`else
`define TCPCS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define TCPCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/tcpcs_pkg.sv @@
// Shared types, constants and helpers of the TCP client segment receiver.
// No dependencies; the design files refer to it by scoped names, the bench imports it.
`timescale 1ns / 1ps

package tcpcs_pkg;

    localparam int WORD_W     = 16;
    localparam int SEQ_W      = 32;
    localparam int ADDR_W     = 32;
    localparam int PORT_W     = 16;
    localparam int FLAG_W     = 8;
    localparam int IDX_W      = 4;
    localparam int CODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 96;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 104;
    localparam int M_TUSER_W  = 3;

    localparam logic [WORD_W-1:0] PROTO_TCP = 16'd6;
    localparam logic [WORD_W-1:0] SUM_GOOD  = 16'hffff;
    localparam logic [FLAG_W-1:0] RST_BIT   = 8'h04;
    localparam logic [IDX_W-1:0]  IDX_MAX   = 4'd15;

    // Word positions inside the TCP header
    localparam logic [IDX_W-1:0] POS_SRC_PORT = 4'd0;
    localparam logic [IDX_W-1:0] POS_DST_PORT = 4'd1;
    localparam logic [IDX_W-1:0] POS_SEQ_HI   = 4'd2;
    localparam logic [IDX_W-1:0] POS_SEQ_LO   = 4'd3;
    localparam logic [IDX_W-1:0] POS_FLAGS    = 4'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ACK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYN_ACK_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIN_CODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIN_ACK_CODE = 3'd5;

    // Reset values of the configuration
    localparam logic [SEQ_W-1:0]  RESET_START_SEQ    = 32'd1;
    localparam logic [SEQ_W-1:0]  RESET_START_ACK    = 32'd1;
    localparam logic [FLAG_W-1:0] RESET_SYN_ACK_CODE = 8'd18;
    localparam logic [FLAG_W-1:0] RESET_ACK_CODE     = 8'd16;
    localparam logic [FLAG_W-1:0] RESET_FIN_CODE     = 8'd1;
    localparam logic [FLAG_W-1:0] RESET_FIN_ACK_CODE = 8'd17;

    // Reported connection state codes
    localparam logic [CODE_W-1:0] CODE_CLOSED      = 3'd0;
    localparam logic [CODE_W-1:0] CODE_SYN_SENT    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_ESTABLISHED = 3'd2;
    localparam logic [CODE_W-1:0] CODE_FIN_WAIT1   = 3'd3;
    localparam logic [CODE_W-1:0] CODE_FIN_WAIT2   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_TIME_WAIT   = 3'd5;

    typedef enum logic [5:0] {
        ST_CLOSED      = 6'b000001,
        ST_SYN_SENT    = 6'b000010,
        ST_ESTABLISHED = 6'b000100,
        ST_FIN_WAIT1   = 6'b001000,
        ST_FIN_WAIT2   = 6'b010000,
        ST_TIME_WAIT   = 6'b100000
    } conn_state_t;

    // One segment word after the input register
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic [WORD_W-1:0] pseudo;
    } word_item_t;

    // One result word
    typedef struct packed {
        logic              ok;
        logic              rst;
        logic              ack;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  ack_num;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
        logic [CODE_W-1:0] state;
    } result_t;

    // Configuration write towards the core
    typedef struct packed {
        logic                  wr;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    function automatic logic [CODE_W-1:0] state_code(input conn_state_t s);
        logic [CODE_W-1:0] c;
        case (s)
            ST_CLOSED:      c = CODE_CLOSED;
            ST_SYN_SENT:    c = CODE_SYN_SENT;
            ST_ESTABLISHED: c = CODE_ESTABLISHED;
            ST_FIN_WAIT1:   c = CODE_FIN_WAIT1;
            ST_FIN_WAIT2:   c = CODE_FIN_WAIT2;
            ST_TIME_WAIT:   c = CODE_TIME_WAIT;
            default:        c = CODE_CLOSED;
        endcase
        return c;
    endfunction

    // Ones' complement add with end-around carry
    function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

@@ rtl/core/tcpcs_in_stage.sv @@
// Input register of the segment receiver: masks an odd tail byte and folds
// the pseudo header into one ones' complement word. Uses tcpcs_pkg.
`timescale 1ns / 1ps

module tcpcs_in_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tcpcs_pkg::WORD_W-1:0]   seg_word,
    input  logic                           last_word,
    input  logic                           odd_tail,
    input  logic [tcpcs_pkg::ADDR_W-1:0]   src_address,
    input  logic [tcpcs_pkg::ADDR_W-1:0]   dst_address,
    input  logic [tcpcs_pkg::WORD_W-1:0]   seg_length,
    input  logic                           advance,
    output logic                           item_valid,
    output tcpcs_pkg::word_item_t          item
);

    logic                         valid_reg;
    tcpcs_pkg::word_item_t        item_reg;
    tcpcs_pkg::word_item_t        item_next;
    logic [18:0]                  psum;
    logic [16:0]                  fold;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        psum = {3'b0, src_address[31:16]} + {3'b0, src_address[15:0]}
             + {3'b0, dst_address[31:16]} + {3'b0, dst_address[15:0]}
             + {3'b0, tcpcs_pkg::PROTO_TCP} + {3'b0, seg_length};
        // fold twice: the second carry cannot ripple again
        fold = {1'b0, psum[15:0]} + {14'b0, psum[18:16]};
        item_next.pseudo = fold[15:0] + {15'b0, fold[16]};
        item_next.last   = last_word;
        item_next.word   = (last_word && odd_tail) ? {seg_word[15:8], 8'h00} : seg_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/core/tcpcs_seg_core.sv @@
// Segment state of the receiver: running checksum, header captures and the
// client connection state machine. Uses tcpcs_pkg and the assertion header.
`timescale 1ns / 1ps
`include "tcp_client_segment_fsm_top_assert.svh"

module tcpcs_seg_core
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  tcpcs_pkg::word_item_t   item,
    input  tcpcs_pkg::cfg_wr_t      cfg,
    output tcpcs_pkg::result_t      result
);

    tcpcs_pkg::conn_state_t              state_reg, state_next;
    logic [tcpcs_pkg::SEQ_W-1:0]         seq_reg, seq_next;
    logic [tcpcs_pkg::SEQ_W-1:0]         ack_reg, ack_next;
    logic [tcpcs_pkg::WORD_W-1:0]        sum_reg, sum_next;
    logic [tcpcs_pkg::IDX_W-1:0]         idx_reg;
    logic [tcpcs_pkg::SEQ_W-1:0]         cap_seq_reg, cap_seq_next;
    logic [tcpcs_pkg::FLAG_W-1:0]        cap_flags_reg, cap_flags_next;
    logic [tcpcs_pkg::PORT_W-1:0]        cap_src_reg, cap_src_next;
    logic [tcpcs_pkg::PORT_W-1:0]        cap_dst_reg, cap_dst_next;
    logic [tcpcs_pkg::FLAG_W-1:0]        syn_ack_code_reg;
    logic [tcpcs_pkg::FLAG_W-1:0]        ack_code_reg;
    logic [tcpcs_pkg::FLAG_W-1:0]        fin_code_reg;
    logic [tcpcs_pkg::FLAG_W-1:0]        fin_ack_code_reg;
    logic [tcpcs_pkg::WORD_W-1:0]        sum_base;
    logic                                sum_ok;
    logic                                rst_hit;
    logic                                ack_hit;

    // Checksum and captures for this word
    always_comb
    begin
        sum_base = (idx_reg == tcpcs_pkg::POS_SRC_PORT) ? item.pseudo : sum_reg;
        sum_next = tcpcs_pkg::ones_add(sum_base, item.word);
        sum_ok   = (sum_next == tcpcs_pkg::SUM_GOOD);

        cap_src_next   = cap_src_reg;
        cap_dst_next   = cap_dst_reg;
        cap_seq_next   = cap_seq_reg;
        cap_flags_next = cap_flags_reg;
        case (idx_reg)
            tcpcs_pkg::POS_SRC_PORT: cap_src_next = item.word;
            tcpcs_pkg::POS_DST_PORT: cap_dst_next = item.word;
            tcpcs_pkg::POS_SEQ_HI:   cap_seq_next = {item.word, cap_seq_reg[15:0]};
            tcpcs_pkg::POS_SEQ_LO:   cap_seq_next = {cap_seq_reg[31:16], item.word};
            tcpcs_pkg::POS_FLAGS:    cap_flags_next = item.word[7:0];
            default:                 ;
        endcase
    end

    // Connection state machine, evaluated on the closing word of a good segment
    always_comb
    begin
        state_next = state_reg;
        seq_next   = seq_reg;
        ack_next   = ack_reg;
        rst_hit    = 1'b0;
        ack_hit    = 1'b0;
        if (item.last && sum_ok)
        begin
            if ((cap_flags_next & tcpcs_pkg::RST_BIT) != '0)
            begin
                rst_hit    = 1'b1;
                state_next = tcpcs_pkg::ST_CLOSED;
            end
            else
            begin
                case (state_reg)
                    tcpcs_pkg::ST_CLOSED,
                    tcpcs_pkg::ST_SYN_SENT:
                    begin
                        if (cap_flags_next == syn_ack_code_reg)
                        begin
                            ack_hit    = 1'b1;
                            seq_next   = seq_reg + 32'd1;
                            ack_next   = cap_seq_next + 32'd1;
                            state_next = tcpcs_pkg::ST_ESTABLISHED;
                        end
                    end
                    tcpcs_pkg::ST_ESTABLISHED,
                    tcpcs_pkg::ST_FIN_WAIT1:
                    begin
                        if (cap_flags_next == ack_code_reg)
                        begin
                            state_next = tcpcs_pkg::ST_FIN_WAIT2;
                        end
                    end
                    tcpcs_pkg::ST_FIN_WAIT2,
                    tcpcs_pkg::ST_TIME_WAIT:
                    begin
                        if ((cap_flags_next == fin_code_reg) ||
                            (cap_flags_next == fin_ack_code_reg))
                        begin
                            ack_hit    = 1'b1;
                            seq_next   = seq_reg + 32'd1;
                            ack_next   = cap_seq_next + 32'd1;
                            state_next = tcpcs_pkg::ST_TIME_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result.ok       = sum_ok;
        result.rst      = rst_hit;
        result.ack      = ack_hit;
        result.seq      = seq_next;
        result.ack_num  = ack_next;
        result.src_port = cap_dst_next;
        result.dst_port = cap_src_next;
        result.state    = tcpcs_pkg::state_code(state_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= tcpcs_pkg::ST_CLOSED;
            seq_reg          <= tcpcs_pkg::RESET_START_SEQ;
            ack_reg          <= tcpcs_pkg::RESET_START_ACK;
            sum_reg          <= '0;
            idx_reg          <= '0;
            cap_seq_reg      <= '0;
            cap_flags_reg    <= '0;
            cap_src_reg      <= '0;
            cap_dst_reg      <= '0;
            syn_ack_code_reg <= tcpcs_pkg::RESET_SYN_ACK_CODE;
            ack_code_reg     <= tcpcs_pkg::RESET_ACK_CODE;
            fin_code_reg     <= tcpcs_pkg::RESET_FIN_CODE;
            fin_ack_code_reg <= tcpcs_pkg::RESET_FIN_ACK_CODE;
        end
        else if (advance)
        begin
            cap_seq_reg   <= cap_seq_next;
            cap_flags_reg <= cap_flags_next;
            cap_src_reg   <= cap_src_next;
            cap_dst_reg   <= cap_dst_next;
            state_reg     <= state_next;
            seq_reg       <= seq_next;
            ack_reg       <= ack_next;
            if (item.last)
            begin
                sum_reg <= '0;
                idx_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                if (idx_reg != tcpcs_pkg::IDX_MAX)
                begin
                    idx_reg <= idx_reg + 4'd1;
                end
            end
        end
        else if (cfg.wr)
        begin
            case (cfg.index)
                tcpcs_pkg::CFG_START_SEQ:    seq_reg <= cfg.data;
                tcpcs_pkg::CFG_START_ACK:    ack_reg <= cfg.data;
                tcpcs_pkg::CFG_SYN_ACK_CODE: syn_ack_code_reg <= cfg.data[7:0];
                tcpcs_pkg::CFG_ACK_CODE:     ack_code_reg <= cfg.data[7:0];
                tcpcs_pkg::CFG_FIN_CODE:     fin_code_reg <= cfg.data[7:0];
                tcpcs_pkg::CFG_FIN_ACK_CODE: fin_ack_code_reg <= cfg.data[7:0];
                default:                     ;
            endcase
        end
    end

    `TCPCS_ASSERT_NEXT(a_last_clears_index, clk, rst_n, advance && item.last, idx_reg == '0)
    `TCPCS_ASSERT_NEXT(a_drop_holds_state, clk, rst_n, advance && item.last && !sum_ok, $stable(state_reg))
    `TCPCS_ASSERT_NEXT(a_rst_closes, clk, rst_n, advance && rst_hit, state_reg == tcpcs_pkg::ST_CLOSED)
    `TCPCS_ASSERT_NEXT(a_ack_state, clk, rst_n, advance && ack_hit, (state_reg == tcpcs_pkg::ST_ESTABLISHED) || (state_reg == tcpcs_pkg::ST_TIME_WAIT))
    `TCPCS_ASSERT_NOW(a_ack_needs_good, clk, rst_n, ack_hit || rst_hit, item.last && sum_ok)

endmodule

@@ rtl/core/tcpcs_out_stage.sv @@
// Result register of the segment receiver: holds one result word until the
// downstream side takes it. Uses tcpcs_pkg.
`timescale 1ns / 1ps

module tcpcs_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  tcpcs_pkg::result_t   result,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tcpcs_pkg::result_t   out_result
);

    logic                 valid_reg;
    tcpcs_pkg::result_t   result_reg;

    // room when empty or when the held word leaves this cycle
    assign free       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

@@ rtl/core/tcp_client_segment_fsm_top.sv @@
// Top level of the TCP client segment receiver.
// Depends on tcpcs_pkg, tcpcs_in_stage, tcpcs_seg_core and tcpcs_out_stage.
//
// s_* stream: one 16-bit segment word per transfer, network order, tlast on the
//   closing word, tuser flags an odd tail byte. The pseudo header fields ride
//   in tdata with every word; only the opening word of a segment uses them.
// m_* stream: one result word per segment after its closing word: checksum
//   verdict, RST seen, ACK request, reply numbers, ports and connection state.
//   A failed checksum still returns a word with verdict 0.
// cfg_* channel: writes the six registers; cfg_ready drops while a word waits
//   in the input register, so write only while no segment word is in flight.
// Timing: one word per cycle sustained while the result register has room. A closing
//   word's result is loaded from the input register into the result register, which
//   drives m_tvalid; checksum, capture and state update sit between the two registers.
// Reset: rst_n clears both valid flags, sets CLOSED, loads the default start
//   numbers and flag codes.
// Stall: while a result waits, non-closing words keep flowing; a closing word
//   holds in the input register, dropping s_tready, until the result leaves.
`timescale 1ns / 1ps

module tcp_client_segment_fsm_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // stream in
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [15:0] seg_word, [47:16] src_address, [79:48] dst_address, [95:80] seg_length
    input  logic [tcpcs_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                  s_tlast,
    // [0] odd_tail
    input  logic [tcpcs_pkg::S_TUSER_W-1:0]       s_tuser,
    // stream out
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [31:0] reply_seq, [63:32] reply_ack, [79:64] reply_src_port,
    // [95:80] reply_dst_port, [98:96] conn_state, [103:99] zero
    output logic [tcpcs_pkg::M_TDATA_W-1:0]       m_tdata,
    // [0] checksum_ok, [1] reset_seen, [2] send_ack
    output logic [tcpcs_pkg::M_TUSER_W-1:0]       m_tuser,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [tcpcs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tcpcs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    tcpcs_pkg::word_item_t   item;
    tcpcs_pkg::result_t      result;
    tcpcs_pkg::result_t      out_result;
    tcpcs_pkg::cfg_wr_t      cfg;
    logic                    item_valid;
    logic                    advance;
    logic                    out_free;

    // hold configuration writes while a word sits in the input register
    assign cfg_ready = !item_valid;
    assign cfg.wr    = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // advance a held word; a closing word needs room for its result
    assign advance = item_valid && (!item.last || out_free);

    tcpcs_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .seg_word    (s_tdata[15:0]),
        .last_word   (s_tlast),
        .odd_tail    (s_tuser[0]),
        .src_address (s_tdata[47:16]),
        .dst_address (s_tdata[79:48]),
        .seg_length  (s_tdata[95:80]),
        .advance     (advance),
        .item_valid  (item_valid),
        .item        (item)
    );

    tcpcs_seg_core u_seg_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    tcpcs_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && item.last),
        .result     (result),
        .free       (out_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // pack the result word, pad to whole bytes
    assign m_tdata = {5'b0, out_result.state, out_result.dst_port, out_result.src_port,
                      out_result.ack_num, out_result.seq};
    assign m_tuser = {out_result.ack, out_result.rst, out_result.ok};

endmodule

@@ sim/testbench.sv @@
// Self-checking bench for tcp_client_segment_fsm_top: a scoreboard class follows each segment
// and the connection state, and module-level tasks drive the segment and configuration ports.
// Depends on tcpcs_pkg and the block itself.
`timescale 1ns / 1ps

import tcpcs_pkg::*;

class reply_scoreboard;
    logic [SEQ_W-1:0]  start_seq_r;
    logic [SEQ_W-1:0]  start_ack_r;
    logic [FLAG_W-1:0] syn_ack_code_r;
    logic [FLAG_W-1:0] ack_code_r;
    logic [FLAG_W-1:0] fin_code_r;
    logic [FLAG_W-1:0] fin_ack_code_r;

    logic [CODE_W-1:0] conn_code;
    logic [SEQ_W-1:0]  seq_num;
    logic [SEQ_W-1:0]  ack_num;
    logic [WORD_W-1:0] run_sum;
    logic [IDX_W-1:0]  word_pos;
    logic [SEQ_W-1:0]  rx_seq;
    logic [FLAG_W-1:0] rx_flags;
    logic [PORT_W-1:0] rx_src_port;
    logic [PORT_W-1:0] rx_dst_port;

    result_t pending_replies[$];
    int      errors;

    function new();
        start_seq_r    = RESET_START_SEQ;
        start_ack_r    = RESET_START_ACK;
        syn_ack_code_r = RESET_SYN_ACK_CODE;
        ack_code_r     = RESET_ACK_CODE;
        fin_code_r     = RESET_FIN_CODE;
        fin_ack_code_r = RESET_FIN_ACK_CODE;
        conn_code      = CODE_CLOSED;
        seq_num        = RESET_START_SEQ;
        ack_num        = RESET_START_ACK;
        run_sum        = '0;
        word_pos       = '0;
        rx_seq         = '0;
        rx_flags       = '0;
        rx_src_port    = '0;
        rx_dst_port    = '0;
        errors         = 0;
    endfunction

    // Ones' complement add, carry folded back in
    function logic [WORD_W-1:0] csum_add(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        logic [WORD_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        t = {1'b0, t[WORD_W-1:0]} + {{WORD_W{1'b0}}, t[WORD_W]};
        return t[WORD_W-1:0];
    endfunction

    function logic [WORD_W-1:0] pseudo_sum(input logic [ADDR_W-1:0] src,
                                           input logic [ADDR_W-1:0] dst,
                                           input logic [WORD_W-1:0] len);
        logic [WORD_W-1:0] s;
        s = '0;
        s = csum_add(s, src[31:16]);
        s = csum_add(s, src[15:0]);
        s = csum_add(s, dst[31:16]);
        s = csum_add(s, dst[15:0]);
        s = csum_add(s, PROTO_TCP);
        s = csum_add(s, len);
        return s;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_START_SEQ:
            begin
                start_seq_r = data;
                seq_num     = data;
            end
            CFG_START_ACK:
            begin
                start_ack_r = data;
                ack_num     = data;
            end
            CFG_SYN_ACK_CODE: syn_ack_code_r = data[FLAG_W-1:0];
            CFG_ACK_CODE:     ack_code_r = data[FLAG_W-1:0];
            CFG_FIN_CODE:     fin_code_r = data[FLAG_W-1:0];
            CFG_FIN_ACK_CODE: fin_ack_code_r = data[FLAG_W-1:0];
            default:          ;
        endcase
    endfunction

    // Follow one accepted segment word; queue the reply word on a closing word
    function void take_word(input logic [WORD_W-1:0] word, input bit last, input bit odd,
                            input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
                            input logic [WORD_W-1:0] len);
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] s;
        result_t           r;
        w = (last && odd) ? (word & 16'hff00) : word;
        s = (word_pos == '0) ? pseudo_sum(src, dst, len) : run_sum;
        s = csum_add(s, w);
        case (word_pos)
            POS_SRC_PORT: rx_src_port = w;
            POS_DST_PORT: rx_dst_port = w;
            POS_SEQ_HI:   rx_seq[31:16] = w;
            POS_SEQ_LO:   rx_seq[15:0] = w;
            POS_FLAGS:    rx_flags = w[FLAG_W-1:0];
            default:      ;
        endcase
        if (!last)
        begin
            run_sum = s;
            if (word_pos != IDX_MAX)
                word_pos = word_pos + 1'b1;
            return;
        end
        run_sum  = '0;
        word_pos = '0;
        r        = '0;
        r.ok     = (s == SUM_GOOD);
        if (r.ok)
        begin
            if ((rx_flags & RST_BIT) != '0)
            begin
                r.rst     = 1'b1;
                conn_code = CODE_CLOSED;
            end
            else if (conn_code == CODE_CLOSED || conn_code == CODE_SYN_SENT)
            begin
                if (rx_flags == syn_ack_code_r)
                begin
                    ack_num   = rx_seq + 32'd1;
                    seq_num   = seq_num + 32'd1;
                    r.ack     = 1'b1;
                    conn_code = CODE_ESTABLISHED;
                end
            end
            else if (conn_code == CODE_ESTABLISHED || conn_code == CODE_FIN_WAIT1)
            begin
                if (rx_flags == ack_code_r)
                    conn_code = CODE_FIN_WAIT2;
            end
            else if (conn_code == CODE_FIN_WAIT2 || conn_code == CODE_TIME_WAIT)
            begin
                if (rx_flags == fin_code_r || rx_flags == fin_ack_code_r)
                begin
                    ack_num   = rx_seq + 32'd1;
                    seq_num   = seq_num + 32'd1;
                    r.ack     = 1'b1;
                    conn_code = CODE_TIME_WAIT;
                end
            end
        end
        r.seq      = seq_num;
        r.ack_num  = ack_num;
        r.src_port = rx_dst_port;
        r.dst_port = rx_src_port;
        r.state    = conn_code;
        pending_replies.push_back(r);
    endfunction

    function void compare(input string what, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    function void check_reply(input logic [M_TDATA_W-1:0] tdata, input logic [M_TUSER_W-1:0] tuser);
        result_t e;
        if (pending_replies.size() == 0)
        begin
            errors++;
            $display("%0t ns: result word with none expected, expected nothing, got %h / %h",
                     $time, tdata, tuser);
            return;
        end
        e = pending_replies.pop_front();
        compare("checksum_ok", 32'(e.ok), 32'(tuser[0]));
        compare("reset_seen", 32'(e.rst), 32'(tuser[1]));
        compare("send_ack", 32'(e.ack), 32'(tuser[2]));
        compare("reply_seq", e.seq, tdata[31:0]);
        compare("reply_ack", e.ack_num, tdata[63:32]);
        compare("reply_src_port", 32'(e.src_port), 32'(tdata[79:64]));
        compare("reply_dst_port", 32'(e.dst_port), 32'(tdata[95:80]));
        compare("conn_state", 32'(e.state), 32'(tdata[98:96]));
    endfunction

    function void flush_leftovers();
        if (pending_replies.size() != 0)
        begin
            errors += pending_replies.size();
            $display("%0t ns: result words missing, expected %0d more, got 0",
                     $time, pending_replies.size());
            pending_replies.delete();
        end
    endfunction
endclass

module testbench;

    // Register indexes past the end of the list; writes to them are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // [15:0] seg_word, [47:16] src_address, [79:48] dst_address, [95:80] seg_length
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    // [0] odd_tail
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [31:0] reply_seq, [63:32] reply_ack, [79:64] reply_src_port,
    // [95:80] reply_dst_port, [98:96] conn_state
    logic [M_TDATA_W-1:0]   m_tdata;
    // [0] checksum_ok, [1] reset_seen, [2] send_ack
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    reply_scoreboard sb = new();

    // Traffic shaping knobs, changed between phases
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;
    int gap_pct      = 10;
    int stall_pct    = 6;
    int words_sent   = 0;

    tcp_client_segment_fsm_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: check every accepted word, then choose the next tready.
    // Values read just after the edge are the ones the edge sampled.
    initial
    begin : reply_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_reply(m_tdata, m_tuser);
            if (hold_request)
            begin
                // long hold-off: let the block back up into its input
                hold_request = 1'b0;
                hold_left    = 200;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (quiet)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(99) < stall_pct)
            begin
                stall_left = $urandom_range(19, 1) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one word and hold it until accepted; tvalid stays high afterwards
    // so that back-to-back words need only one assignment per edge
    task automatic push_word(input logic [WORD_W-1:0] word, input bit last, input bit odd,
                             input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
                             input logic [WORD_W-1:0] len);
        if (!quiet && $urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, dst, src, word};
        s_tlast  <= last;
        s_tuser  <= odd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_word(word, last, odd, src, dst, len);
        words_sent++;
    endtask

    // Build a segment of n words, with the given flag byte in word 6 when n > 6, and a correct checksum,
    // then optionally flip one bit to make it fail. The fix-up word sits in the
    // checksum slot (word 8) or, for short segments, in the closing word.
    task automatic send_segment(input int n, input logic [FLAG_W-1:0] flags, input bit corrupt);
        logic [WORD_W-1:0] words [0:23];
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [WORD_W-1:0] len;
        logic [WORD_W-1:0] s;
        int                fix;
        bit                odd;
        src = $urandom;
        dst = $urandom;
        fix = (n > 8) ? 8 : n - 1;
        odd = (fix != n - 1) && ($urandom_range(3) == 0);
        len = ($urandom_range(7) == 0) ? WORD_W'($urandom) : WORD_W'(n * 2 - odd);
        for (int i = 0; i < n; i++)
            words[i] = WORD_W'($urandom);
        if (n > 6)
            words[6][FLAG_W-1:0] = flags;
        words[fix] = '0;
        if (odd)
            words[n-1][7:0] = 8'h00;
        s = sb.pseudo_sum(src, dst, len);
        for (int i = 0; i < n; i++)
            s = sb.csum_add(s, words[i]);
        words[fix] = ~s;
        if (corrupt)
            words[$urandom_range(n - 1)] ^= WORD_W'(1) << $urandom_range(15);
        // only the opening word's pseudo header counts; fill the rest with junk
        for (int i = 0; i < n; i++)
        begin
            if (i == 0)
                push_word(words[i], n == 1, odd, src, dst, len);
            else
                push_word(words[i], i == n - 1, (i == n - 1) ? odd : bit'($urandom_range(1)),
                          $urandom, $urandom, WORD_W'($urandom));
        end
    endtask

    // Favour the flag byte that moves the connection on from where it stands
    function automatic logic [FLAG_W-1:0] pick_flags();
        int                r;
        logic [FLAG_W-1:0] junk;
        r    = $urandom_range(99);
        junk = FLAG_W'($urandom);
        if (r < 10)
            return junk | RST_BIT;
        if (r < 20)
            return junk;
        case (sb.conn_code)
            CODE_CLOSED, CODE_SYN_SENT:       return sb.syn_ack_code_r;
            CODE_ESTABLISHED, CODE_FIN_WAIT1: return sb.ack_code_r;
            default:                          return (r < 60) ? sb.fin_code_r : sb.fin_ack_code_r;
        endcase
    endfunction

    // Mostly well-formed segments; some corrupted, some raw noise words
    task automatic random_traffic(input int count);
        int target;
        int r;
        int q;
        int n;
        target = words_sent + count;
        while (words_sent < target)
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                n = $urandom_range(5, 1);
                for (int i = 0; i < n; i++)
                    push_word(WORD_W'($urandom),
                              (i == n - 1) ? ($urandom_range(3) != 0) : ($urandom_range(4) == 0),
                              bit'($urandom_range(1)), $urandom, $urandom, WORD_W'($urandom));
            end
            else
            begin
                q = $urandom_range(99);
                if (q < 84)
                    n = $urandom_range(12, 8);
                else if (q < 95)
                    n = $urandom_range(7, 1);
                else
                    n = $urandom_range(22, 13);
                send_segment(n, pick_flags(), r < 25);
            end
        end
    endtask

    // Drop tvalid, wait for every outstanding result word, then let the
    // two pipeline registers empty
    task automatic settle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.pending_replies.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        sb.flush_leftovers();
    endtask

    // Hold the write until accepted; the caller drops cfg_valid after a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(index, data);
    endtask

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme single-word segments, then a full client close
        // with the default codes (SYN-ACK, ACK, FIN-ACK)
        push_word(16'hffff, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
        push_word(16'h0000, 1'b1, 1'b0, 32'h0, 32'h0, 16'h0);
        send_segment(8, RESET_SYN_ACK_CODE, 1'b0);
        send_segment(8, RESET_ACK_CODE, 1'b0);
        send_segment(8, RESET_FIN_ACK_CODE, 1'b0);
        random_traffic(180);
        settle();

        // Extremes: start numbers at the top so the first increment wraps,
        // zero and all-ones flag codes, and the unused register indexes
        write_reg(CFG_START_SEQ, 32'hffff_ffff);
        write_reg(CFG_START_ACK, 32'hffff_ffff);
        write_reg(CFG_SYN_ACK_CODE, 32'h0000_0000);
        write_reg(CFG_ACK_CODE, 32'h0000_0010);
        write_reg(CFG_FIN_CODE, 32'h0000_00ff);
        write_reg(CFG_FIN_ACK_CODE, 32'h0000_0011);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        cfg_valid <= 1'b0;
        @(posedge clk);
        hold_request = 1'b1;
        random_traffic(200);
        settle();

        // Zero start numbers, random codes without the RST bit, light idling
        write_reg(CFG_START_SEQ, 32'h0);
        write_reg(CFG_START_ACK, 32'h0);
        write_reg(CFG_SYN_ACK_CODE, $urandom & ~32'(RST_BIT));
        write_reg(CFG_ACK_CODE, $urandom & ~32'(RST_BIT));
        write_reg(CFG_FIN_CODE, $urandom & ~32'(RST_BIT));
        write_reg(CFG_FIN_ACK_CODE, $urandom & ~32'(RST_BIT));
        cfg_valid <= 1'b0;
        @(posedge clk);
        gap_pct   = 3;
        stall_pct = 2;
        random_traffic(200);
        settle();

        // Default codes back, random start numbers, full rate on both sides
        write_reg(CFG_START_SEQ, $urandom);
        write_reg(CFG_START_ACK, $urandom);
        write_reg(CFG_SYN_ACK_CODE, 32'(RESET_SYN_ACK_CODE));
        write_reg(CFG_ACK_CODE, 32'(RESET_ACK_CODE));
        write_reg(CFG_FIN_CODE, 32'(RESET_FIN_CODE));
        write_reg(CFG_FIN_ACK_CODE, 32'(RESET_FIN_ACK_CODE));
        cfg_valid <= 1'b0;
        @(posedge clk);
        quiet = 1'b1;
        random_traffic(200);
        settle();

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
